FILE: src/color_lut_3d_diagonal_interp_core_macros.svh
// assertion macros for the 3d lut color grading core
`ifndef COLOR_LUT_3D_DIAGONAL_INTERP_CORE_MACROS_SVH
`define COLOR_LUT_3D_DIAGONAL_INTERP_CORE_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising clk_i edge outside reset
`define CLUT3D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("clut3d assertion failed");
// condition that must never be seen outside reset
`define CLUT3D_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("clut3d forbidden condition seen");
`else
`define CLUT3D_ASSERT(lbl, prop)
`define CLUT3D_ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: src/clut3d_pkg.sv
// shared constants, types and helper functions of the 3d lut color grading core
package clut3d_pkg;

  localparam int GRID_SIZE           = 32;
  localparam int ENTRY_FRACTION_BITS = 12;

  localparam int PIX_W       = 8;
  localparam int ENTRY_W     = 13;
  localparam int INDEX_W     = 15;
  localparam int CELL_SHIFT  = 3;
  localparam int CELL_W      = $clog2(GRID_SIZE);
  localparam int TABLE_DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int WEIGHT_W    = CELL_SHIFT + 1;
  localparam int NUM_W       = ENTRY_W + CELL_SHIFT;
  localparam int SCALE_W     = NUM_W + 8;
  localparam int DIV_SHIFT   = CELL_SHIFT + ENTRY_FRACTION_BITS;
  localparam int TRIPLE_W    = 3 * ENTRY_W;
  localparam int S_DATA_W    = 80;
  localparam int M_DATA_W    = 3 * PIX_W;

  // tdata field offsets on the slave side
  localparam int IDX_LSB   = 0;
  localparam int ENT_LSB   = IDX_LSB + INDEX_W;
  localparam int PIX_LSB   = ENT_LSB + TRIPLE_W;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_PIXEL = 1'b1
  } req_type_e;

  typedef logic [2:0][PIX_W-1:0]   rgb_t;
  typedef logic [2:0][ENTRY_W-1:0] entry_t;

  typedef struct packed {
    logic              is_pix;
    logic              wr_ok;
    logic              set_loaded;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    entry_t            wdata;
    rgb_t              pixel;
  } front_t;

  typedef struct packed {
    logic   loaded;
    rgb_t   pixel;
    entry_t ent_a;
    entry_t ent_b;
  } mid_t;

  function automatic logic [CELL_W-1:0] cell_of(logic [PIX_W-1:0] v);
    logic [PIX_W-CELL_SHIFT-1:0] raw;
    raw = v[PIX_W-1:CELL_SHIFT];
    // top cell folds onto the last full cell
    if (int'(raw) > GRID_SIZE - 2) begin
      return CELL_W'(GRID_SIZE - 2);
    end
    return CELL_W'(raw);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(logic [ADDR_W-1:0] r,
                                                logic [ADDR_W-1:0] g,
                                                logic [ADDR_W-1:0] b);
    return r + ADDR_W'(GRID_SIZE) * (g + ADDR_W'(GRID_SIZE) * b);
  endfunction

endpackage

FILE: src/clut3d_ram.sv
// generic ram: one write port, two registered read ports
module clut3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: src/clut3d_front.sv
// input stage: unpacks a beat and computes the two table addresses
module clut3d_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       up_valid_i,
  output logic                       up_ready_o,
  input  logic                       up_type_i,
  input  logic [clut3d_pkg::S_DATA_W-1:0] up_data_i,
  output logic                       dn_valid_o,
  input  logic                       dn_ready_i,
  output clut3d_pkg::front_t         dn_data_o
);
  import clut3d_pkg::*;

  logic              v0_q;
  front_t            s0_q;
  front_t            s0_d;
  logic              adv0;
  logic [INDEX_W-1:0] idx;
  rgb_t              pix;
  logic [CELL_W-1:0] cr, cg, cb;
  logic              in_range;

  assign adv0       = !v0_q || dn_ready_i;
  assign up_ready_o = adv0;

  always_comb begin
    idx = up_data_i[IDX_LSB +: INDEX_W];
    pix = rgb_t'(up_data_i[PIX_LSB +: M_DATA_W]);
    cr  = cell_of(pix[0]);
    cg  = cell_of(pix[1]);
    cb  = cell_of(pix[2]);
    in_range = 32'(idx) < 32'(TABLE_DEPTH);

    s0_d.is_pix     = (req_type_e'(up_type_i) == REQ_PIXEL);
    s0_d.wr_ok      = !s0_d.is_pix && in_range;
    s0_d.set_loaded = s0_d.wr_ok && (32'(idx) == 32'(TABLE_DEPTH - 1));
    s0_d.addr_a     = s0_d.is_pix ? addr_of(ADDR_W'(cr), ADDR_W'(cg), ADDR_W'(cb))
                                  : ADDR_W'(idx);
    s0_d.addr_b     = addr_of(ADDR_W'(cr) + ADDR_W'(1), ADDR_W'(cg) + ADDR_W'(1),
                              ADDR_W'(cb) + ADDR_W'(1));
    s0_d.wdata      = entry_t'(up_data_i[ENT_LSB +: TRIPLE_W]);
    s0_d.pixel      = pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv0) begin
      v0_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0 && up_valid_i) begin
      s0_q <= s0_d;
    end
  end

  assign dn_valid_o = v0_q;
  assign dn_data_o  = s0_q;

endmodule

FILE: src/clut3d_blend.sv
// blend: weighted sum of both entries, x255, saturate; pixel if not loaded
module clut3d_blend (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              up_valid_i,
  output logic              up_ready_o,
  input  clut3d_pkg::mid_t  up_data_i,
  output logic              dn_valid_o,
  input  logic              dn_ready_i,
  output clut3d_pkg::rgb_t  dn_rgb_o
);
  import clut3d_pkg::*;

  logic                         v2_q;
  logic                         v3_q;
  logic                         adv2;
  logic                         adv3;
  logic                         loaded2_q;
  rgb_t                         pix2_q;
  logic [2:0][NUM_W-1:0]        num2_q;
  logic [2:0][NUM_W-1:0]        num2_d;
  rgb_t                         rgb3_q;
  rgb_t                         rgb3_d;
  logic [2:0][SCALE_W-1:0]      scaled;
  logic [2:0][SCALE_W-1:0]      quot;

  assign adv3       = !v3_q || dn_ready_i;
  assign adv2       = !v2_q || adv3;
  assign up_ready_o = adv2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num2_d[k] = NUM_W'(WEIGHT_W'(1 << CELL_SHIFT)
                         - WEIGHT_W'(up_data_i.pixel[k][CELL_SHIFT-1:0]))
                  * NUM_W'(up_data_i.ent_a[k])
                + NUM_W'(up_data_i.pixel[k][CELL_SHIFT-1:0]) * NUM_W'(up_data_i.ent_b[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // times 255 as shift and subtract
      scaled[k] = (SCALE_W'(num2_q[k]) << 8) - SCALE_W'(num2_q[k]);
      quot[k]   = scaled[k] >> DIV_SHIFT;
      if (!loaded2_q) begin
        rgb3_d[k] = pix2_q[k];
      end else if (quot[k] > SCALE_W'(255)) begin
        rgb3_d[k] = '1;
      end else begin
        rgb3_d[k] = quot[k][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv2) begin
        v2_q <= up_valid_i;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && up_valid_i) begin
      num2_q    <= num2_d;
      loaded2_q <= up_data_i.loaded;
      pix2_q    <= up_data_i.pixel;
    end
    if (adv3 && v2_q) begin
      rgb3_q <= rgb3_d;
    end
  end

  assign dn_valid_o = v3_q;
  assign dn_rgb_o   = rgb3_q;

endmodule

FILE: src/color_lut_3d_diagonal_interp_core.sv
// top level of the 3d lut color grading core with diagonal interpolation
//
// channel   dir  beat contents
// s_axis    in   tuser: request kind; tdata: index, entry rgb, pixel rgb
// m_axis    out  tdata: graded pixel rgb (pixel requests only)
//
// one beat per clock in and out while m_axis does not stall; a pixel passes the stages
// input register, table read, weighted sum, and scale and saturate on its way to m_axis.
// the table is one 32768 x 39 ram with one write port and two read ports, the
// two corners of a pixel are read in the same cycle.
// table writes take effect in order with pixels and give no output beat.
// reset clears the valid bits and the loaded flag, table contents stay undefined.
// each stage holds on a stall and takes a new beat as soon as it is empty.
`include "color_lut_3d_diagonal_interp_core_macros.svh"

module color_lut_3d_diagonal_interp_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [14:0] entry_index, [27:15] entry_red, [40:28] entry_green, [53:41] entry_blue,
  // [61:54] pixel_red, [69:62] pixel_green, [77:70] pixel_blue, [79:78] zero
  input  logic [clut3d_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [0] req_type
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  output logic [clut3d_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import clut3d_pkg::*;

  logic              front_valid;
  front_t            front_data;
  logic              blend_ready;
  logic              adv1;
  logic              ram_we;
  logic              v1_q;
  logic              loaded1_q;
  rgb_t              pix1_q;
  logic              loaded_q;
  logic [TRIPLE_W-1:0] rdata_a;
  logic [TRIPLE_W-1:0] rdata_b;
  mid_t              mid;
  rgb_t              out_rgb;

  clut3d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (s_axis_tvalid),
    .up_ready_o (s_axis_tready),
    .up_type_i  (s_axis_tuser),
    .up_data_i  (s_axis_tdata),
    .dn_valid_o (front_valid),
    .dn_ready_i (adv1),
    .dn_data_o  (front_data)
  );

  // table stage: writes and reads leave the input register in beat order
  assign adv1   = !v1_q || blend_ready;
  assign ram_we = adv1 && front_valid && front_data.wr_ok;

  clut3d_ram #(
    .WIDTH (TRIPLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (front_data.addr_a),
    .wdata_i   (front_data.wdata),
    .re_i      (adv1),
    .raddr_a_i (front_data.addr_a),
    .raddr_b_i (front_data.addr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      loaded_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= front_valid && front_data.is_pix;
      end
      if (ram_we && front_data.set_loaded) begin
        loaded_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && front_valid && front_data.is_pix) begin
      loaded1_q <= loaded_q;
      pix1_q    <= front_data.pixel;
    end
  end

  always_comb begin
    mid.loaded = loaded1_q;
    mid.pixel  = pix1_q;
    mid.ent_a  = entry_t'(rdata_a);
    mid.ent_b  = entry_t'(rdata_b);
  end

  clut3d_blend u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (v1_q),
    .up_ready_o (blend_ready),
    .up_data_i  (mid),
    .dn_valid_o (m_axis_tvalid),
    .dn_ready_i (m_axis_tready),
    .dn_rgb_o   (out_rgb)
  );

  assign m_axis_tdata = M_DATA_W'(out_rgb);

  `CLUT3D_ASSERT(a_loaded_sticky, loaded_q |=> loaded_q)
  `CLUT3D_ASSERT(a_write_no_beat, (adv1 && front_valid && !front_data.is_pix) |=> !v1_q)
  `CLUT3D_ASSERT_NEVER(a_loaded_in_flight, !loaded_q && v1_q && loaded1_q)

endmodule

FILE: sim/tb.sv
// self-checking testbench for the 3d lut color grading core with stalls on both sides
`timescale 1ns / 1ps

module tb;
  import clut3d_pkg::*;

  localparam int LATENCY      = 4;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 200;
  localparam int DIAG_STEP    = 1 + GRID_SIZE + GRID_SIZE * GRID_SIZE;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PIXEL,
    ROW_FILL
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [INDEX_W-1:0] idx;
    entry_t             ent;
    rgb_t               pix;
    bit                 has_want;
    rgb_t               want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;

  // shadow of the grading table, channel 0 is red
  entry_t lut_mem [TABLE_DEPTH];
  bit     lut_written [TABLE_DEPTH];
  bit     lut_loaded;
  rgb_t   graded_q [$];
  row_t   rows [$];

  int    errors;
  int    writes_sent;
  int    pixels_sent;
  int    beats_checked;
  int    idle_cycles;
  bit    steady_run;
  bit    hold_req;
  string field_name [3] = '{"out_red", "out_green", "out_blue"};

  color_lut_3d_diagonal_interp_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    if (steady_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic entry_t ent3(int r, int g, int b);
    entry_t e;
    e[0] = ENTRY_W'(r);
    e[1] = ENTRY_W'(g);
    e[2] = ENTRY_W'(b);
    return e;
  endfunction

  function automatic rgb_t px3(int r, int g, int b);
    rgb_t p;
    p[0] = PIX_W'(r);
    p[1] = PIX_W'(g);
    p[2] = PIX_W'(b);
    return p;
  endfunction

  function automatic row_t mk_row(row_kind_e kind, int idx, entry_t ent, rgb_t pix,
                                  bit has_want, rgb_t want);
    row_t rw;
    rw.kind     = kind;
    rw.idx      = INDEX_W'(idx);
    rw.ent      = ent;
    rw.pix      = pix;
    rw.has_want = has_want;
    rw.want     = want;
    return rw;
  endfunction

  // values mostly in 0..1.0, some exactly 0 or 1.0, some above 1.0
  function automatic entry_t rand_entry();
    entry_t e;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 15))
        0: e[k] = '0;
        1: e[k] = ENTRY_W'(4096);
        2: e[k] = ENTRY_W'($urandom_range(4097, 8191));
        default: e[k] = ENTRY_W'($urandom_range(0, 4096));
      endcase
    end
    return e;
  endfunction

  // channel values lean on the cell edges and the folded top cell
  function automatic rgb_t rand_pixel();
    rgb_t p;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: p[k] = 8'd0;
          1: p[k] = 8'd255;
          2: p[k] = 8'd247;
          default: p[k] = 8'd248;
        endcase
      end else begin
        p[k] = PIX_W'($urandom_range(0, 255));
      end
    end
    return p;
  endfunction

  function automatic logic [PIX_W-1:0] blend_channel(logic [ENTRY_W-1:0] a,
                                                     logic [ENTRY_W-1:0] b,
                                                     logic [2:0] m);
    logic [31:0] num;
    logic [31:0] scaled;
    num    = (32'd8 - 32'(m)) * 32'(a) + 32'(m) * 32'(b);
    scaled = (num * 32'd255) >> DIV_SHIFT;
    return (scaled > 32'd255) ? 8'd255 : scaled[7:0];
  endfunction

  // table address of the lower corner of the pixel's lattice box
  function automatic int corner_a(rgb_t pix);
    int pos [3];
    for (int k = 0; k < 3; k++) begin
      pos[k] = int'(pix[k]) >> CELL_SHIFT;
      if (pos[k] > GRID_SIZE - 2) pos[k] = GRID_SIZE - 2;
    end
    return pos[0] + GRID_SIZE * (pos[1] + GRID_SIZE * pos[2]);
  endfunction

  function automatic rgb_t grade_pixel(rgb_t pix);
    rgb_t res;
    int   base;
    int   diag;
    if (!lut_loaded) return pix;
    base = corner_a(pix);
    diag = base + DIAG_STEP;
    for (int k = 0; k < 3; k++) begin
      res[k] = blend_channel(lut_mem[base][k], lut_mem[diag][k], pix[k][2:0]);
    end
    return res;
  endfunction

  task automatic send_beat(req_type_e kind, logic [INDEX_W-1:0] idx, entry_t ent, rgb_t pix,
                           bit has_want, rgb_t want);
    int gap;
    int base;
    // a graded pixel only reads corners that were written before it
    if (kind == REQ_PIXEL && lut_loaded) begin
      base = corner_a(pix);
      if (!lut_written[base]) begin
        send_beat(REQ_WRITE, INDEX_W'(base), rand_entry(), rand_pixel(), 1'b0, '0);
      end
      if (!lut_written[base + DIAG_STEP]) begin
        send_beat(REQ_WRITE, INDEX_W'(base + DIAG_STEP), rand_entry(), rand_pixel(),
                  1'b0, '0);
      end
    end
    if ($urandom_range(0, 63) == 0) steady_run = !steady_run;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, pix[2], pix[1], pix[0], ent[2], ent[1], ent[0], idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == REQ_WRITE) begin
      lut_mem[idx]     = ent;
      lut_written[idx] = 1'b1;
      if (idx == INDEX_W'(TABLE_DEPTH - 1)) lut_loaded = 1'b1;
      writes_sent++;
    end else begin
      graded_q.push_back(has_want ? want : grade_pixel(pix));
      pixels_sent++;
    end
  endtask

  // writing the last entry sets the loaded flag; other corners are written on demand
  task automatic fill_table();
    send_beat(REQ_WRITE, INDEX_W'(TABLE_DEPTH - 1), rand_entry(), rand_pixel(), 1'b0, '0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = REQ_WRITE;
    s_axis_tdata  = '0;
    lut_loaded    = 1'b0;
    steady_run    = 1'b0;
    hold_req      = 1'b0;

    // pass-through while the table is not loaded
    rows.push_back(mk_row(ROW_PIXEL, 0, ent3(0, 0, 0), px3(0, 0, 0), 1, px3(0, 0, 0)));
    rows.push_back(mk_row(ROW_PIXEL, 0, ent3(0, 0, 0), px3(255, 255, 255), 1,
                          px3(255, 255, 255)));
    rows.push_back(mk_row(ROW_PIXEL, TABLE_DEPTH - 1, ent3(8191, 8191, 8191),
                          px3(8'h55, 8'hAA, 8'h0F), 1, px3(8'h55, 8'hAA, 8'h0F)));
    rows.push_back(mk_row(ROW_WRITE, 0, ent3(4096, 0, 8191), px3(255, 255, 255), 0, '0));
    rows.push_back(mk_row(ROW_WRITE, TABLE_DEPTH - 2, ent3(4096, 4096, 4096),
                          px3(0, 0, 0), 0, '0));
    rows.push_back(mk_row(ROW_PIXEL, 0, ent3(0, 0, 0), px3(128, 64, 200), 1,
                          px3(128, 64, 200)));
    rows.push_back(mk_row(ROW_FILL, 0, '0, '0, 0, '0));
    // zero weight on the diagonal corner: entry 0 alone, blue saturates
    rows.push_back(mk_row(ROW_WRITE, 0, ent3(4096, 0, 8191), px3(0, 0, 0), 0, '0));
    rows.push_back(mk_row(ROW_WRITE, 1 + GRID_SIZE + GRID_SIZE * GRID_SIZE,
                          ent3(0, 4096, 2048), px3(0, 0, 0), 0, '0));
    rows.push_back(mk_row(ROW_PIXEL, 0, ent3(0, 0, 0), px3(0, 0, 0), 1, px3(255, 0, 255)));
    rows.push_back(mk_row(ROW_PIXEL, 0, ent3(0, 0, 0), px3(7, 7, 7), 0, '0));
    rows.push_back(mk_row(ROW_PIXEL, 0, ent3(0, 0, 0), px3(255, 255, 255), 0, '0));
    rows.push_back(mk_row(ROW_PIXEL, 0, ent3(0, 0, 0), px3(248, 0, 247), 0, '0));
    rows.push_back(mk_row(ROW_PIXEL, 0, ent3(0, 0, 0), px3(8, 16, 240), 0, '0));
    // rewriting the last entry keeps the table loaded
    rows.push_back(mk_row(ROW_WRITE, TABLE_DEPTH - 1, ent3(0, 0, 0), px3(0, 0, 0), 0, '0));
    rows.push_back(mk_row(ROW_PIXEL, 0, ent3(0, 0, 0), px3(255, 255, 255), 0, '0));
    rows.push_back(mk_row(ROW_WRITE, TABLE_DEPTH - 1, ent3(8191, 8191, 8191),
                          px3(0, 0, 0), 0, '0));
    rows.push_back(mk_row(ROW_PIXEL, 0, ent3(0, 0, 0), px3(255, 255, 255), 1,
                          px3(255, 255, 255)));
    rows.push_back(mk_row(ROW_PIXEL, TABLE_DEPTH - 1, ent3(8191, 8191, 8191),
                          px3(100, 150, 50), 0, '0));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_FILL: fill_table();
        ROW_WRITE: send_beat(REQ_WRITE, rows[i].idx, rows[i].ent, rows[i].pix, 1'b0, '0);
        default: send_beat(REQ_PIXEL, rows[i].idx, rows[i].ent, rows[i].pix,
                           rows[i].has_want, rows[i].want);
      endcase
    end

    hold_req = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_beat(REQ_WRITE, INDEX_W'($urandom), rand_entry(), rand_pixel(), 1'b0, '0);
      end else begin
        send_beat(REQ_PIXEL, INDEX_W'($urandom), rand_entry(), rand_pixel(), 1'b0, '0);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (graded_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY * 4) @(posedge clk_i);

    $display("run covered %0d table writes (loaded flag, reloads, corners) and %0d pixels",
             writes_sent, pixels_sent);
    $display("%0d graded beats checked, %0d field mismatches", beats_checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // output side: random stalls plus one long hold once the random traffic starts
  initial begin
    int  n;
    bit  held;
    m_axis_tready = 1'b0;
    held          = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 15)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    rgb_t got;
    rgb_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (graded_q.size() == 0) begin
        $error("graded beat %h with no pixel pending", m_axis_tdata);
        errors++;
      end else begin
        want = graded_q.pop_front();
        beats_checked++;
        for (int k = 0; k < 3; k++) begin
          if (got[k] !== want[k]) begin
            $error("%s: expected %0d, got %0d", field_name[k], want[k], got[k]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no beat moved for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
